/* hdl/olc_pkg.sv */
// Shared types, codes and constants of the ownership lifecycle checker.
// No dependencies; every other file of the block refers to this package.
package olc_pkg;

   localparam int NUM_OBJECTS_DEF  = 3;
   localparam int MAX_FINDINGS_DEF = 16;

   localparam int ADDR_W  = 64;
   localparam int SEQ_W   = 32;
   localparam int COUNT_W = 16;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_EXPORT  = 3'd1,
      OP_MOVE    = 3'd2,
      OP_IMPORT  = 3'd3,
      OP_RETURN  = 3'd4,
      OP_RELEASE = 3'd5,
      OP_END     = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      LC_ABSENT   = 2'd0,
      LC_EXPORTED = 2'd1,
      LC_IMPORTED = 2'd2,
      LC_RELEASED = 2'd3
   } obj_state_type;

   typedef enum logic [2:0] {
      RULE_BEFORE_IMPORT = 3'd0,
      RULE_NOT_CONSUMER  = 3'd1,
      RULE_TWICE         = 3'd2,
      RULE_NEVER         = 3'd3,
      RULE_STALE         = 3'd4,
      RULE_OUT_OF_ORDER  = 3'd5,
      RULE_CHILD         = 3'd6
   } rule_type;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [1:0]        object;
      logic [ADDR_W-1:0] address;
      logic              from_consumer;
      logic              is_base_path;
      logic [SEQ_W-1:0]  sequence_req;
      logic              dropped_flag;
   } event_type;

   typedef struct packed {
      rule_type           rule;
      logic [1:0]         finding_object;
      logic [SEQ_W-1:0]   finding_sequence;
      logic [COUNT_W-1:0] finding_number;
      logic               stored;
      logic               incomplete;
   } finding_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      sat_inc = (value == {COUNT_W{1'b1}}) ? value : value + COUNT_W'(1);
   endfunction

endpackage

/* hdl/olc_ifs.sv */
// Valid/ready channel interfaces of the ownership lifecycle checker:
// event input, finding output and register write. Uses olc_pkg widths.
interface olc_req_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  opcode;
   logic [1:0]                  object;
   logic [olc_pkg::ADDR_W-1:0]  address;
   logic                        from_consumer;
   logic                        is_base_path;
   logic [olc_pkg::SEQ_W-1:0]   sequence_req;
   logic                        dropped_flag;

   modport source (output valid, opcode, object, address, from_consumer, is_base_path,
                   sequence_req, dropped_flag, input ready);
   modport sink   (input valid, opcode, object, address, from_consumer, is_base_path,
                   sequence_req, dropped_flag, output ready);
endinterface

interface olc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  rule;
   logic [1:0]                  finding_object;
   logic [olc_pkg::SEQ_W-1:0]   finding_sequence;
   logic [olc_pkg::COUNT_W-1:0] finding_number;
   logic                        stored;
   logic                        incomplete;
   logic                        last;

   modport source (output valid, rule, finding_object, finding_sequence, finding_number,
                   stored, incomplete, last, input ready);
   modport sink   (input valid, rule, finding_object, finding_sequence, finding_number,
                   stored, incomplete, last, output ready);
endinterface

interface olc_csr_if;
   logic valid;
   logic ready;
   logic loc_strict;

   modport source (output valid, loc_strict, input ready);
   modport sink   (input valid, loc_strict, output ready);
endinterface

/* hdl/olc_core.sv */
// Per-object lifecycle state, location store, finding counter and rule checks.
// Builds the findings of one accepted event combinationally. Uses olc_pkg.
module olc_core #(
   parameter int NUM_OBJECTS  = olc_pkg::NUM_OBJECTS_DEF,
   parameter int MAX_FINDINGS = olc_pkg::MAX_FINDINGS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  olc_pkg::event_type       evt,
   input  logic                     csr_write,
   input  logic                     csr_strict,
   output olc_pkg::finding_type     slots [NUM_OBJECTS],
   output logic [NUM_OBJECTS-1:0]   mask
);

   localparam int OBJ_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

   olc_pkg::obj_state_type              state_ff [NUM_OBJECTS];
   olc_pkg::obj_state_type              state_in [NUM_OBJECTS];
   logic [olc_pkg::ADDR_W-1:0]          loc_ff   [NUM_OBJECTS];
   logic [olc_pkg::ADDR_W-1:0]          loc_in   [NUM_OBJECTS];
   logic [olc_pkg::COUNT_W-1:0]         count_ff;
   logic [olc_pkg::COUNT_W-1:0]         count_in;
   logic                                strict_ff;
   logic                                strict_in;

   logic                                obj_ok;
   logic [OBJ_W-1:0]                    idx;
   olc_pkg::obj_state_type              cur;
   logic                                hit;
   olc_pkg::rule_type                   hit_rule;
   logic [olc_pkg::COUNT_W-1:0]         run;

   assign strict_in = csr_write ? csr_strict : strict_ff;
   assign obj_ok    = (evt.object < 2'(NUM_OBJECTS));
   assign idx       = evt.object[OBJ_W-1:0];
   assign cur       = state_ff[idx];

   always_comb begin
      state_in = state_ff;
      loc_in   = loc_ff;
      count_in = count_ff;
      mask     = '0;
      for (int i = 0; i < NUM_OBJECTS; i++) begin
         slots[i] = '0;
      end
      hit      = 1'b0;
      hit_rule = olc_pkg::RULE_BEFORE_IMPORT;
      run      = count_ff;
      if (accept) begin
         unique case (olc_pkg::opcode_type'(evt.opcode))
            olc_pkg::OP_END: begin
               // one never-released finding per live object, then clear all
               for (int i = 0; i < NUM_OBJECTS; i++) begin
                  if (state_ff[i] == olc_pkg::LC_EXPORTED ||
                      state_ff[i] == olc_pkg::LC_IMPORTED) begin
                     mask[i]                     = 1'b1;
                     slots[i].rule               = olc_pkg::RULE_NEVER;
                     slots[i].finding_object     = 2'(i);
                     slots[i].finding_sequence   = '0;
                     slots[i].finding_number     = olc_pkg::sat_inc(run);
                     slots[i].stored             = (run < olc_pkg::COUNT_W'(MAX_FINDINGS));
                     slots[i].incomplete         = evt.dropped_flag;
                     run                         = olc_pkg::sat_inc(run);
                  end
                  state_in[i] = olc_pkg::LC_ABSENT;
                  loc_in[i]   = '0;
               end
               count_in = '0;
            end
            olc_pkg::OP_EXPORT: begin
               if (obj_ok) begin
                  state_in[idx] = olc_pkg::LC_EXPORTED;
                  loc_in[idx]   = evt.address;
               end
            end
            olc_pkg::OP_MOVE: begin
               if (obj_ok) begin
                  loc_in[idx] = evt.address;
               end
            end
            olc_pkg::OP_IMPORT: begin
               if (obj_ok) begin
                  hit           = (cur != olc_pkg::LC_EXPORTED);
                  hit_rule      = olc_pkg::RULE_OUT_OF_ORDER;
                  state_in[idx] = olc_pkg::LC_IMPORTED;
                  loc_in[idx]   = evt.address;
               end
            end
            olc_pkg::OP_RETURN: begin
               if (obj_ok && cur == olc_pkg::LC_IMPORTED) begin
                  state_in[idx] = olc_pkg::LC_EXPORTED;
               end
            end
            olc_pkg::OP_RELEASE: begin
               if (obj_ok) begin
                  if (!evt.is_base_path) begin
                     hit      = evt.from_consumer;
                     hit_rule = olc_pkg::RULE_CHILD;
                  end else begin
                     if (cur == olc_pkg::LC_RELEASED) begin
                        hit      = 1'b1;
                        hit_rule = olc_pkg::RULE_TWICE;
                     end else if (evt.from_consumer) begin
                        if (cur != olc_pkg::LC_IMPORTED) begin
                           hit      = 1'b1;
                           hit_rule = olc_pkg::RULE_BEFORE_IMPORT;
                        end else begin
                           hit      = strict_ff && (evt.address != loc_ff[idx]);
                           hit_rule = olc_pkg::RULE_STALE;
                        end
                     end else begin
                        hit      = (cur == olc_pkg::LC_IMPORTED);
                        hit_rule = olc_pkg::RULE_NOT_CONSUMER;
                     end
                     state_in[idx] = olc_pkg::LC_RELEASED;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (hit) begin
         mask[0]                   = 1'b1;
         slots[0].rule             = hit_rule;
         slots[0].finding_object   = evt.object;
         slots[0].finding_sequence = evt.sequence_req;
         slots[0].finding_number   = olc_pkg::sat_inc(count_ff);
         slots[0].stored           = (count_ff < olc_pkg::COUNT_W'(MAX_FINDINGS));
         slots[0].incomplete       = 1'b0;
         count_in                  = olc_pkg::sat_inc(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OBJECTS; i++) begin
            state_ff[i] <= olc_pkg::LC_ABSENT;
            loc_ff[i]   <= '0;
         end
         count_ff  <= '0;
         strict_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loc_ff    <= loc_in;
         count_ff  <= count_in;
         strict_ff <= strict_in;
      end
   end

endmodule

/* hdl/olc_emit.sv */
// Finding register of the checker: holds the findings of one event and
// hands them out one per transfer, lowest slot first. Uses olc_pkg.
module olc_emit #(
   parameter int NUM_OBJECTS = olc_pkg::NUM_OBJECTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  olc_pkg::finding_type     slots [NUM_OBJECTS],
   input  logic [NUM_OBJECTS-1:0]   mask,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output olc_pkg::finding_type     rsp_finding,
   output logic                     rsp_last,
   output logic                     take_ok
);

   olc_pkg::finding_type     slots_ff [NUM_OBJECTS];
   logic [NUM_OBJECTS-1:0]   mask_ff;
   logic [NUM_OBJECTS-1:0]   mask_in;
   logic [NUM_OBJECTS-1:0]   lowest;
   logic [NUM_OBJECTS-1:0]   rest;
   logic                     pop;

   assign lowest    = mask_ff & (~mask_ff + NUM_OBJECTS'(1));
   assign rest      = mask_ff & ~lowest;
   assign rsp_valid = |mask_ff;
   assign rsp_last  = (rest == '0);
   assign pop       = rsp_valid & rsp_ready;
   // take a new event when empty or when the final finding leaves now
   assign take_ok   = !rsp_valid || (pop && rsp_last);

   always_comb begin
      rsp_finding = slots_ff[0];
      for (int i = NUM_OBJECTS - 1; i >= 0; i--) begin
         if (lowest[i]) begin
            rsp_finding = slots_ff[i];
         end
      end
   end

   always_comb begin
      if (load) begin
         mask_in = mask;
      end else if (pop) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= slots;
      end
   end

endmodule

/* hdl/ownership_lifecycle_checker_top.sv */
// Ownership lifecycle checker, top level.
// A finding is offered on rsp the cycle after its event transfers on req.
// Throughput: one event per cycle while rsp does not stall; an end-of-log event
//   with k live objects (k <= NUM_OBJECTS) holds the register until all k transfer.
// Reset (synchronous, active high): all objects absent, locations and finding
//   count zero, strict location check off, finding register empty.
module ownership_lifecycle_checker_top #(
   parameter int NUM_OBJECTS  = olc_pkg::NUM_OBJECTS_DEF,
   parameter int MAX_FINDINGS = olc_pkg::MAX_FINDINGS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   olc_req_if.sink    req_bus,
   olc_rsp_if.source  rsp_bus,
   olc_csr_if.sink    csr_bus
);

   olc_pkg::event_type     evt;
   olc_pkg::finding_type   slots [NUM_OBJECTS];
   olc_pkg::finding_type   rsp_finding;
   logic [NUM_OBJECTS-1:0] mask;
   logic                   accept;
   logic                   take_ok;
   logic                   rsp_last;
   logic                   rsp_valid;

   // Register writes land at once; the port never stalls.
   assign csr_bus.ready = 1'b1;

   // Event transfer: gated only by the finding register being free or draining.
   assign req_bus.ready = take_ok;
   assign accept        = req_bus.valid & take_ok;

   // Gather the event payload.
   assign evt.opcode        = req_bus.opcode;
   assign evt.object        = req_bus.object;
   assign evt.address       = req_bus.address;
   assign evt.from_consumer = req_bus.from_consumer;
   assign evt.is_base_path  = req_bus.is_base_path;
   assign evt.sequence_req  = req_bus.sequence_req;
   assign evt.dropped_flag  = req_bus.dropped_flag;

   // State lookup, rule checks and finding numbering for the accepted event.
   olc_core #(
      .NUM_OBJECTS  (NUM_OBJECTS),
      .MAX_FINDINGS (MAX_FINDINGS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .evt        (evt),
      .csr_write  (csr_bus.valid),
      .csr_strict (csr_bus.loc_strict),
      .slots      (slots),
      .mask       (mask)
   );

   // Hold the findings and drain them one transfer at a time.
   olc_emit #(
      .NUM_OBJECTS (NUM_OBJECTS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .slots       (slots),
      .mask        (mask),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid),
      .rsp_finding (rsp_finding),
      .rsp_last    (rsp_last),
      .take_ok     (take_ok)
   );

   // Drive the finding channel.
   assign rsp_bus.valid            = rsp_valid;
   assign rsp_bus.rule             = rsp_finding.rule;
   assign rsp_bus.finding_object   = rsp_finding.finding_object;
   assign rsp_bus.finding_sequence = rsp_finding.finding_sequence;
   assign rsp_bus.finding_number   = rsp_finding.finding_number;
   assign rsp_bus.stored           = rsp_finding.stored;
   assign rsp_bus.incomplete       = rsp_finding.incomplete;
   assign rsp_bus.last             = rsp_last;

endmodule

/* hdl/olc_checker.sv */
// Port-level checks of the ownership lifecycle checker and their bind.
// Sees only the top level's channels; uses olc_pkg codes.
module olc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [2:0]                  rsp_rule,
   input logic [olc_pkg::COUNT_W-1:0] rsp_number,
   input logic                        rsp_incomplete,
   input logic                        rsp_last
);

   // stalled finding holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_number) && $stable(rsp_rule))
      else $error("finding changed while stalled");

   // no new event while a multi-finding group is still draining
   a_group_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("event taken in the middle of a finding group");

   // a group continues right after a non-final transfer
   a_group_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("finding group broke off");

   // numbers inside a group count up by one, or stay saturated
   a_group_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         (rsp_number == $past(rsp_number) + olc_pkg::COUNT_W'(1)) ||
         (rsp_number == {olc_pkg::COUNT_W{1'b1}}))
      else $error("finding numbers not consecutive in group");

   // only never-released findings carry the incomplete flag
   a_incomplete_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_incomplete |-> rsp_rule == olc_pkg::RULE_NEVER)
      else $error("incomplete flag on a non end-of-log finding");

endmodule

bind ownership_lifecycle_checker_top olc_checker u_olc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_rule       (rsp_bus.rule),
   .rsp_number     (rsp_bus.finding_number),
   .rsp_incomplete (rsp_bus.incomplete),
   .rsp_last       (rsp_bus.last)
);

/* verif/olc_finding_checker.sv */
`timescale 1ns / 1ps
// Finding checker: watches the event, finding and register channels of the
// ownership lifecycle checker, predicts findings and compares. Needs olc_pkg, olc_ifs.
module olc_finding_checker (
   input  logic clock,
   input  logic reset,
   olc_req_if   req,
   olc_rsp_if   rsp,
   olc_csr_if   csr,
   output int   fail_count,
   output int   pending,
   output int   findings_checked
);
   import olc_pkg::*;

   typedef struct packed {
      finding_type body;
      logic        last;
   } expected_finding_type;

   expected_finding_type expected_q[$];
   obj_state_type        life_state[NUM_OBJECTS_DEF];
   logic [ADDR_W-1:0]    life_location[NUM_OBJECTS_DEF];
   logic [COUNT_W-1:0]   running_count;
   logic                 strict_mode;
   event_type            req_seen;
   int                   mismatches = 0;
   int                   checked = 0;

   // Queue one expected finding; the running count saturates at all ones.
   function automatic void log_finding(rule_type rule, int obj,
                                       logic [SEQ_W-1:0] seq_no, logic incomplete);
      expected_finding_type item;
      item.body.rule             = rule;
      item.body.finding_object   = 2'(obj);
      item.body.finding_sequence = seq_no;
      item.body.stored           = (int'(running_count) < MAX_FINDINGS_DEF);
      if (running_count != '1)
         running_count++;
      item.body.finding_number   = running_count;
      item.body.incomplete       = incomplete;
      item.last                  = 1'b0;
      expected_q.push_back(item);
   endfunction

   function automatic void predict_findings(event_type ev);
      int            first;
      int            obj;
      obj_state_type was;
      first = expected_q.size();
      obj   = int'(ev.object);
      if (ev.opcode == OP_END) begin
         for (int i = 0; i < NUM_OBJECTS_DEF; i++) begin
            if (life_state[i] == LC_EXPORTED || life_state[i] == LC_IMPORTED)
               log_finding(RULE_NEVER, i, '0, ev.dropped_flag);
         end
         foreach (life_state[i]) begin
            life_state[i]    = LC_ABSENT;
            life_location[i] = '0;
         end
         running_count = '0;
      end else if (obj < NUM_OBJECTS_DEF) begin
         was = life_state[obj];
         case (ev.opcode)
            OP_EXPORT: begin
               life_state[obj]    = LC_EXPORTED;
               life_location[obj] = ev.address;
            end
            OP_MOVE: life_location[obj] = ev.address;
            OP_IMPORT: begin
               if (was != LC_EXPORTED)
                  log_finding(RULE_OUT_OF_ORDER, obj, ev.sequence_req, 1'b0);
               life_state[obj]    = LC_IMPORTED;
               life_location[obj] = ev.address;
            end
            OP_RETURN: begin
               if (was == LC_IMPORTED)
                  life_state[obj] = LC_EXPORTED;
            end
            OP_RELEASE: begin
               if (!ev.is_base_path) begin
                  // child release: flag only when the consumer did it, keep state
                  if (ev.from_consumer)
                     log_finding(RULE_CHILD, obj, ev.sequence_req, 1'b0);
               end else begin
                  if (was == LC_RELEASED)
                     log_finding(RULE_TWICE, obj, ev.sequence_req, 1'b0);
                  else if (ev.from_consumer) begin
                     if (was != LC_IMPORTED)
                        log_finding(RULE_BEFORE_IMPORT, obj, ev.sequence_req, 1'b0);
                     else if (strict_mode && ev.address != life_location[obj])
                        log_finding(RULE_STALE, obj, ev.sequence_req, 1'b0);
                  end else if (was == LC_IMPORTED)
                     log_finding(RULE_NOT_CONSUMER, obj, ev.sequence_req, 1'b0);
                  life_state[obj] = LC_RELEASED;
               end
            end
            default: ;
         endcase
      end
      if (expected_q.size() > first)
         expected_q[expected_q.size()-1].last = 1'b1;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_finding();
      expected_finding_type want;
      if (expected_q.size() == 0) begin
         $error("finding transfer with none expected: rule %0d object %0d sequence %0h",
                rsp.rule, rsp.finding_object, rsp.finding_sequence);
         mismatches++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("rule", 64'(want.body.rule), 64'(rsp.rule));
      compare_field("finding_object", 64'(want.body.finding_object),
                    64'(rsp.finding_object));
      compare_field("finding_sequence", 64'(want.body.finding_sequence),
                    64'(rsp.finding_sequence));
      compare_field("finding_number", 64'(want.body.finding_number),
                    64'(rsp.finding_number));
      compare_field("stored", 64'(want.body.stored), 64'(rsp.stored));
      compare_field("incomplete", 64'(want.body.incomplete), 64'(rsp.incomplete));
      compare_field("last", 64'(want.last), 64'(rsp.last));
      checked++;
   endfunction

   // Old findings leave before new events are predicted, since a finding is registered after its event.
   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         foreach (life_state[i]) begin
            life_state[i]    = LC_ABSENT;
            life_location[i] = '0;
         end
         running_count = '0;
         strict_mode   = 1'b0;
      end else begin
         if (rsp.valid && rsp.ready)
            check_finding();
         if (csr.valid && csr.ready)
            strict_mode = csr.loc_strict;
         if (req.valid && req.ready) begin
            req_seen.opcode        = req.opcode;
            req_seen.object        = req.object;
            req_seen.address       = req.address;
            req_seen.from_consumer = req.from_consumer;
            req_seen.is_base_path  = req.is_base_path;
            req_seen.sequence_req  = req.sequence_req;
            req_seen.dropped_flag  = req.dropped_flag;
            predict_findings(req_seen);
         end
      end
      pending          <= expected_q.size();
      fail_count       <= mismatches;
      findings_checked <= checked;
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Top of the ownership lifecycle checker testbench: clock, reset, stimulus and verdict.
// Needs olc_pkg, olc_ifs, the block's top and olc_finding_checker.
module tb;
   import olc_pkg::*;

   localparam logic [2:0] OP_RESERVED      = 3'd7;
   localparam logic [1:0] OBJ_SCHEMA       = 2'd0;
   localparam logic [1:0] OBJ_ARRAY        = 2'd1;
   localparam logic [1:0] OBJ_STREAM       = 2'd2;
   localparam logic [1:0] OBJ_INVALID      = 2'd3;
   localparam int         RANDOM_PER_PHASE = 62;
   localparam int         SETTLE_CYCLES    = 4;
   localparam int         TAIL_CYCLES      = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   int   events_sent = 0;
   int   fail_count;
   int   pending;
   int   findings_checked;

   // Stimulus-side memory: last address handed out per object, and how far each
   // object has got through its export / import / release lifecycle.
   logic [ADDR_W-1:0] last_addr[4];
   int                life_stage[3];

   olc_req_if req_bus ();
   olc_rsp_if rsp_bus ();
   olc_csr_if csr_bus ();

   ownership_lifecycle_checker_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   olc_finding_checker lifecycle_monitor (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr              (csr_bus),
      .fail_count       (fail_count),
      .pending          (pending),
      .findings_checked (findings_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the finding channel at random; rx_idle_pct sets how often.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   function automatic event_type make_event(logic [2:0] op, logic [1:0] obj,
                                            logic [ADDR_W-1:0] addr, logic consumer,
                                            logic base, logic [SEQ_W-1:0] seq_no,
                                            logic dropped);
      event_type ev;
      ev.opcode        = op;
      ev.object        = obj;
      ev.address       = addr;
      ev.from_consumer = consumer;
      ev.is_base_path  = base;
      ev.sequence_req  = seq_no;
      ev.dropped_flag  = dropped;
      return ev;
   endfunction

   function automatic logic [ADDR_W-1:0] random_addr();
      return {$urandom, $urandom};
   endfunction

   // Draw one event: mostly the next legal step of some object's lifecycle,
   // the rest noise (any opcode, bad object, stray releases, end of log).
   function automatic event_type random_event();
      event_type  ev;
      logic [1:0] obj;
      int         pick;
      obj  = ($urandom_range(0, 99) < 4) ? OBJ_INVALID : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      ev   = make_event(OP_NONE, obj, random_addr(), 1'($urandom), 1'($urandom),
                        $urandom, 1'($urandom));
      if (obj != OBJ_INVALID && pick < 65) begin
         case (life_stage[obj])
            0: begin
               ev.opcode       = OP_EXPORT;
               life_stage[obj] = 1;
            end
            1: begin
               ev.opcode = ($urandom_range(0, 3) == 0) ? OP_MOVE : OP_IMPORT;
               if (ev.opcode == OP_IMPORT)
                  life_stage[obj] = 2;
            end
            2: begin
               pick = $urandom_range(0, 99);
               ev.opcode = OP_RELEASE;
               if (pick < 15) begin
                  ev.opcode       = OP_RETURN;
                  life_stage[obj] = 1;
               end else if (pick < 35)
                  ev.is_base_path = 1'b0;
               else begin
                  ev.is_base_path  = 1'b1;
                  ev.from_consumer = 1'b1;
                  if ($urandom_range(0, 9) != 0)
                     ev.address = last_addr[obj];
                  life_stage[obj] = 3;
               end
            end
            default: begin
               ev.opcode       = OP_EXPORT;
               life_stage[obj] = 1;
            end
         endcase
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            ev.opcode = OP_EXPORT;
         else if (pick < 25)
            ev.opcode = OP_MOVE;
         else if (pick < 45)
            ev.opcode = OP_IMPORT;
         else if (pick < 53)
            ev.opcode = OP_RETURN;
         else if (pick < 85) begin
            ev.opcode       = OP_RELEASE;
            ev.is_base_path = ($urandom_range(0, 99) < 85);
            if ($urandom_range(0, 99) < 70)
               ev.address = last_addr[obj];
         end else if (pick < 90) begin
            ev.opcode  = OP_END;
            life_stage = '{0, 0, 0};
         end else if (pick < 95)
            ev.opcode = ($urandom_range(0, 1) == 0) ? OP_NONE : OP_RESERVED;
         else
            ev.opcode = 3'($urandom);
      end
      if (ev.opcode == OP_EXPORT || ev.opcode == OP_MOVE || ev.opcode == OP_IMPORT)
         last_addr[obj] = ev.address;
      return ev;
   endfunction

   // Present one event and hold it until it transfers. Valid stays high on return
   // so back-to-back events never drop it within a step.
   task automatic send_event(event_type ev);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= ev.opcode;
      req_bus.object        <= ev.object;
      req_bus.address       <= ev.address;
      req_bus.from_consumer <= ev.from_consumer;
      req_bus.is_base_path  <= ev.is_base_path;
      req_bus.sequence_req  <= ev.sequence_req;
      req_bus.dropped_flag  <= ev.dropped_flag;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      events_sent++;
   endtask

   // Drop valid and wait until every predicted finding has transferred.
   task automatic drain_findings();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // Write the strict location check only with the block idle; let an end of
   // log that produced nothing finish too.
   task automatic write_strict(logic strict);
      drain_findings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.loc_strict <= strict;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_random_phase(int tx_pct, int rx_pct, logic strict);
      write_strict(strict);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         // hold the sender once per phase until the finding channel runs dry
         if (i == RANDOM_PER_PHASE / 2)
            drain_findings();
         send_event(random_event());
      end
   endtask

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.opcode        <= OP_NONE;
      req_bus.object        <= OBJ_SCHEMA;
      req_bus.address       <= '0;
      req_bus.from_consumer <= 1'b0;
      req_bus.is_base_path  <= 1'b0;
      req_bus.sequence_req  <= '0;
      req_bus.dropped_flag  <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.loc_strict    <= 1'b0;
      last_addr  = '{default: '0};
      life_stage = '{0, 0, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, strict location on.
      write_strict(1'b1);
      // no-op opcodes, address, flag and sequence bits all high
      send_event(make_event(OP_NONE, OBJ_INVALID, '1, 1'b1, 1'b1, '1, 1'b1));
      send_event(make_event(OP_RESERVED, OBJ_SCHEMA, '1, 1'b1, 1'b1, '1, 1'b1));
      // release before import, then released twice
      send_event(make_event(OP_RELEASE, OBJ_SCHEMA, '0, 1'b1, 1'b1, '0, 1'b0));
      send_event(make_event(OP_RELEASE, OBJ_SCHEMA, '0, 1'b1, 1'b1, 32'd3, 1'b0));
      // import without export is out of order
      send_event(make_event(OP_IMPORT, OBJ_ARRAY, 64'h1234, 1'b0, 1'b1, 32'd4, 1'b0));
      // clean stream path with a return and a re-import
      send_event(make_event(OP_EXPORT, OBJ_STREAM, '0, 1'b0, 1'b1, 32'd5, 1'b0));
      send_event(make_event(OP_MOVE, OBJ_STREAM, '1, 1'b0, 1'b1, 32'd6, 1'b0));
      send_event(make_event(OP_IMPORT, OBJ_STREAM, 64'hbeef, 1'b1, 1'b1, 32'd7, 1'b0));
      send_event(make_event(OP_RETURN, OBJ_STREAM, '0, 1'b0, 1'b1, 32'd8, 1'b0));
      send_event(make_event(OP_RETURN, OBJ_SCHEMA, '0, 1'b0, 1'b1, 32'd9, 1'b0));
      send_event(make_event(OP_IMPORT, OBJ_STREAM, 64'hcafe, 1'b1, 1'b1, 32'd10, 1'b0));
      // child release by consumer flags, by producer does nothing
      send_event(make_event(OP_RELEASE, OBJ_STREAM, '0, 1'b1, 1'b0, 32'd11, 1'b0));
      send_event(make_event(OP_RELEASE, OBJ_STREAM, '0, 1'b0, 1'b0, 32'd12, 1'b0));
      // consumer release away from the import location: stale
      send_event(make_event(OP_RELEASE, OBJ_STREAM, 64'hcaff, 1'b1, 1'b1, '1, 1'b0));
      // producer release of an imported object
      send_event(make_event(OP_EXPORT, OBJ_SCHEMA, 64'h77, 1'b0, 1'b1, 32'd14, 1'b0));
      send_event(make_event(OP_IMPORT, OBJ_SCHEMA, 64'h77, 1'b0, 1'b1, 32'd15, 1'b0));
      send_event(make_event(OP_RELEASE, OBJ_SCHEMA, 64'h77, 1'b0, 1'b1, 32'd16, 1'b0));
      // producer release of an exported object: silent
      send_event(make_event(OP_EXPORT, OBJ_ARRAY, 64'h88, 1'b0, 1'b1, 32'd17, 1'b0));
      send_event(make_event(OP_RELEASE, OBJ_ARRAY, 64'h88, 1'b0, 1'b1, 32'd18, 1'b0));
      // out-of-range object is ignored
      send_event(make_event(OP_EXPORT, OBJ_INVALID, 64'h99, 1'b0, 1'b1, 32'd19, 1'b0));
      send_event(make_event(OP_RELEASE, OBJ_INVALID, 64'h99, 1'b1, 1'b1, 32'd20, 1'b0));
      // end of log with nothing live: no finding, dropped flag lost
      send_event(make_event(OP_END, OBJ_SCHEMA, '0, 1'b0, 1'b0, 32'd21, 1'b1));
      // three live objects at end of log, events dropped
      send_event(make_event(OP_EXPORT, OBJ_SCHEMA, 64'h1, 1'b0, 1'b1, 32'd22, 1'b0));
      send_event(make_event(OP_EXPORT, OBJ_ARRAY, 64'h2, 1'b0, 1'b1, 32'd23, 1'b0));
      send_event(make_event(OP_IMPORT, OBJ_STREAM, 64'h3, 1'b0, 1'b1, 32'd24, 1'b0));
      send_event(make_event(OP_END, OBJ_STREAM, '0, 1'b0, 1'b0, 32'd25, 1'b1));

      // Random phases: sender light and receiver heavy, then swapped, then flat out.
      run_random_phase(9, 70, 1'b1);
      run_random_phase(70, 9, 1'b0);
      run_random_phase(0, 0, 1'b1);

      drain_findings();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d events and checked %0d findings over both location modes,",
               events_sent, findings_checked);
      $display("three sender/receiver stall mixes and a forced drain in each mix.");
      if (fail_count == 0)
         $display("ownership_lifecycle_checker_top regression: pass");
      else
         $display("ownership_lifecycle_checker_top regression: fail");
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin
      #5_000_000;
      $display("ownership_lifecycle_checker_top regression: fail");
      $finish;
   end

endmodule
